>>> src/plst_pkg.sv
`default_nettype none

package plst_pkg;

  // Widths of the result fields
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned COUNT_W = 5;

  // What was done with the table for one request
  typedef enum logic [1:0] {
    ACT_REFRESH = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_REPLACE = 2'd2
  } action_e;

endpackage

`default_nettype wire

>>> src/plst_ram.sv
`default_nettype none

module plst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> src/peer_last_seen_table_unit.sv
`default_nettype none

// Channel  Direction  Handshake               Payload
// -------  ---------  ----------------------  ---------------------------------
// in       input      in_valid_i / in_stall_o  node_id_i[31:0], now_ms_i[31:0]
// out      output     out_valid_o / out_stall_i slot_o[3:0], action_o[1:0],
//                                              entry_count_o[4:0]
//
// One request at a time. Each table entry is scanned by a memory read state, then a
// compare state; the entries scanned are the filled count, all entries when full,
// stopping early on a match. The registered memory read is not overlapped across
// entries. Reset clears the fill count and every other register of this module;
// the table memories are never read before written. A stalled result holds the
// write-back until it drains.

module peer_last_seen_table_unit
  import plst_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic [31:0]         node_id_i,
  input  wire logic [31:0]         now_ms_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic [SLOT_W-1:0]   slot_o,
  output      logic [1:0]          action_o,
  output      logic [COUNT_W-1:0]  entry_count_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_WRITE
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  idx_q;
  logic [31:0]       id_q;
  logic [31:0]       now_q;
  logic              hit_q;
  logic [IDX_W-1:0]  hit_idx_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic [31:0]       best_time_q;
  logic              out_valid_q;
  logic [SLOT_W-1:0] slot_q;
  action_e           action_q;
  logic [COUNT_W-1:0] entry_count_q;

  logic [31:0]       rd_id;
  logic [31:0]       rd_time;
  logic              full;
  logic [CNT_W-1:0]  scan_lim;
  logic [CNT_W-1:0]  idx_nxt;
  logic              out_free;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  action_e           wr_act;
  logic [CNT_W-1:0]  count_d;
  logic [SLOT_W+IDX_W-1:0]   slot_ext;
  logic [COUNT_W+CNT_W-1:0]  count_ext;

  // Table storage
  plst_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_idx),
    .wdata_i (id_q),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (rd_id)
  );

  plst_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_idx),
    .wdata_i (now_q),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (rd_time)
  );

  // Scan bounds and write-back decision
  always_comb begin
    full     = (count_q == FULL_CNT);
    scan_lim = full ? FULL_CNT : count_q;
    idx_nxt  = idx_q + CNT_W'(1);
    out_free = !out_valid_q || !out_stall_i;
    wr_en    = (state_q == ST_WRITE) && out_free;
    count_d  = count_q;
    if (hit_q) begin
      wr_idx = hit_idx_q;
      wr_act = ACT_REFRESH;
    end else if (!full) begin
      wr_idx  = count_q[IDX_W-1:0];
      wr_act  = ACT_APPEND;
      count_d = count_q + CNT_W'(1);
    end else begin
      wr_idx = best_idx_q;
      wr_act = ACT_REPLACE;
    end
    slot_ext  = {{SLOT_W{1'b0}}, wr_idx};
    count_ext = {{COUNT_W{1'b0}}, count_d};
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign slot_o        = slot_q;
  assign action_o      = action_q;
  assign entry_count_o = entry_count_q;

  // Sequencer: scan for match and oldest entry, then write back and report
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      idx_q         <= '0;
      hit_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      hit_idx_q     <= '0;
      best_idx_q    <= '0;
      best_time_q   <= '0;
      id_q          <= '0;
      now_q         <= '0;
      slot_q        <= '0;
      action_q      <= ACT_REFRESH;
      entry_count_q <= '0;
    end else begin
      // result drained; the write-back state sets a new one itself
      if (out_valid_q && !out_stall_i && (state_q != ST_WRITE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            id_q  <= node_id_i;
            now_q <= now_ms_i;
            idx_q <= '0;
            hit_q <= 1'b0;
            state_q <= (count_q == '0) ? ST_WRITE : ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          // oldest time, lowest index on ties
          if (idx_q == '0 || rd_time < best_time_q) begin
            best_time_q <= rd_time;
            best_idx_q  <= idx_q[IDX_W-1:0];
          end
          if (rd_id == id_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= idx_q[IDX_W-1:0];
            state_q   <= ST_WRITE;
          end else if (idx_nxt == scan_lim) begin
            state_q <= ST_WRITE;
          end else begin
            idx_q   <= idx_nxt;
            state_q <= ST_READ;
          end
        end
        ST_WRITE: begin
          if (out_free) begin
            count_q       <= count_d;
            out_valid_q   <= 1'b1;
            slot_q        <= slot_ext[SLOT_W-1:0];
            action_q      <= wr_act;
            entry_count_q <= count_ext[COUNT_W-1:0];
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> verif/peer_last_seen_table_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the peer table, keeps a shadow copy of the table,
// and compares every result against the oldest outstanding prediction.
module peer_last_seen_table_checker
  import plst_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire logic [31:0]        node_id_i,
  input  wire logic [31:0]        now_ms_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire logic [SLOT_W-1:0]  slot_i,
  input  wire logic [1:0]         action_i,
  input  wire logic [COUNT_W-1:0] entry_count_i,
  output int unsigned             mismatches_o,
  output int unsigned             pending_o
);

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    action_e            action;
    logic [COUNT_W-1:0] entry_count;
  } table_result_t;

  // Shadow table; entries past shadow_filled are never looked at
  logic [31:0]   shadow_ids  [TABLE_ENTRIES];
  logic [31:0]   shadow_seen [TABLE_ENTRIES];
  int unsigned   shadow_filled;
  table_result_t expected_results [$];

  initial begin
    shadow_filled = 0;
    mismatches_o  = 0;
    pending_o     = 0;
  end

  // One line per mismatch
  task automatic report_mismatch(input string msg);
    $display("%0t  MISMATCH  %s", $realtime, msg);
    mismatches_o++;
  endtask

  // Refresh on a hit, append while there is room, else evict the oldest
  function automatic table_result_t predict_heartbeat(input logic [31:0] id,
                                                      input logic [31:0] now_ms);
    table_result_t res;
    int unsigned   idx;
    bit            found;
    found = 1'b0;
    idx   = 0;
    for (int unsigned i = 0; i < shadow_filled; i++) begin
      if (!found && shadow_ids[i] == id) begin
        found = 1'b1;
        idx   = i;
      end
    end
    if (found) begin
      res.action = ACT_REFRESH;
    end else if (shadow_filled < TABLE_ENTRIES) begin
      idx = shadow_filled;
      shadow_filled++;
      shadow_ids[idx] = id;
      res.action = ACT_APPEND;
    end else begin
      // strict less-than keeps the lowest index on ties
      for (int unsigned i = 1; i < TABLE_ENTRIES; i++) begin
        if (shadow_seen[i] < shadow_seen[idx])
          idx = i;
      end
      shadow_ids[idx] = id;
      res.action = ACT_REPLACE;
    end
    shadow_seen[idx] = now_ms;
    res.slot         = SLOT_W'(idx);
    res.entry_count  = COUNT_W'(shadow_filled);
    return res;
  endfunction

  // Sample both channels on the clock edge, before anything updates
  always @(posedge clk_i) begin : watch
    table_result_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result slot=%0d action=%0d count=%0d with none pending",
                                    slot_i, action_i, entry_count_i));
        end else begin
          want = expected_results.pop_front();
          if (slot_i !== want.slot)
            report_mismatch($sformatf("slot got %0d want %0d", slot_i, want.slot));
          if (action_i !== want.action)
            report_mismatch($sformatf("action got %0d want %0d", action_i, want.action));
          if (entry_count_i !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      entry_count_i, want.entry_count));
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_results.push_back(predict_heartbeat(node_id_i, now_ms_i));
      pending_o = expected_results.size();
    end
  end

endmodule

>>> verif/peer_last_seen_table_unit_test.sv
`timescale 1ns / 100ps

module peer_last_seen_table_unit_test;
  import plst_pkg::*;

  localparam int unsigned TABLE_ENTRIES     = 16;
  localparam int unsigned RANDOM_HEARTBEATS = 1730;
  localparam int unsigned POOL_SIZE         = 24;
  localparam int unsigned LONG_HOLD         = 300;
  localparam int unsigned DRAIN_CYCLES      = 80;
  localparam int unsigned QUIET_LIMIT       = 4000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [31:0]        node_id_i;
  logic [31:0]        now_ms_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [SLOT_W-1:0]  slot_o;
  logic [1:0]         action_o;
  logic [COUNT_W-1:0] entry_count_o;

  logic        in_taken;
  logic        out_taken;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned sender_calm = 0;
  int unsigned quiet_cycles = 0;

  assign in_taken  = in_valid_i && !in_stall_o;
  assign out_taken = out_valid_o && !out_stall_i;

  always #6 clk_i = ~clk_i;

  peer_last_seen_table_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .node_id_i    (node_id_i),
    .now_ms_i     (now_ms_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .slot_o       (slot_o),
    .action_o     (action_o),
    .entry_count_o(entry_count_o)
  );

  peer_last_seen_table_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) table_watch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .node_id_i    (node_id_i),
    .now_ms_i     (now_ms_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .slot_i       (slot_o),
    .action_i     (action_o),
    .entry_count_i(entry_count_o),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Abort when neither channel moves for too long
  always @(posedge clk_i) begin
    if (in_taken || out_taken)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Random idle pause, with occasional runs of back-to-back traffic
  task automatic draw_pause(inout int unsigned calm_left, output int unsigned pause);
    if (calm_left > 0) begin
      pause = 0;
      calm_left--;
    end else if ($urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(10, 40);
      pause     = 0;
    end else begin
      pause = $urandom_range(0, 10);
    end
  endtask

  // Offer one request and hold it until the block takes it
  task automatic send_heartbeat(input logic [31:0] id, input logic [31:0] stamp);
    int unsigned gap;
    draw_pause(sender_calm, gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    node_id_i  <= id;
    now_ms_i   <= stamp;
    do @(posedge clk_i); while (!in_taken);
  endtask

  // Result side: random stalls, plus one long hold so the input backs up
  initial begin : result_sink
    int unsigned calm_left;
    int unsigned hold;
    int unsigned taken;
    calm_left = 0;
    taken     = 0;
    out_stall_i <= 1'b1;
    wait (rst_ni === 1'b1);
    forever begin
      draw_pause(calm_left, hold);
      if (taken == 200)
        hold = LONG_HOLD;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_taken);
      taken++;
    end
  end

  // Request side and verdict
  initial begin : heartbeat_source
    logic [31:0] id_pool [POOL_SIZE];
    logic [31:0] clock_ms;
    logic [31:0] id;
    logic [31:0] stamp;
    bit          pooled;
    int unsigned pick;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    node_id_i  <= '0;
    now_ms_i   <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Append at the field extremes, then refresh an existing entry
    send_heartbeat(32'h0000_0000, 32'h0000_0000);
    send_heartbeat(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_heartbeat(32'h0000_0000, 32'd5);
    // Fill the table; slots 2..15 share one time
    for (int unsigned k = 0; k < TABLE_ENTRIES - 2; k++)
      send_heartbeat(32'h0000_0100 + k, 32'd100);
    // Evict the clear minimum, then a tie resolved to the lowest slot
    send_heartbeat(32'hA5A5_A5A5, 32'd200);
    send_heartbeat(32'h5A5A_5A5A, 32'd300);
    // Refresh while full, dropping a time to zero, then evict it
    send_heartbeat(32'hFFFF_FFFF, 32'h0000_0000);
    send_heartbeat(32'h1234_5678, 32'd7);

    // Random traffic: mostly a recurring peer set with a rising clock
    for (int unsigned k = 0; k < POOL_SIZE; k++)
      id_pool[k] = $urandom;
    clock_ms = 32'd1000;
    repeat (RANDOM_HEARTBEATS) begin
      pick   = $urandom_range(0, 99);
      pooled = 1'b0;
      if (pick < 80) begin
        id     = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        pooled = 1'b1;
      end else if (pick < 95) begin
        id = $urandom;
      end else begin
        // near miss of a known peer
        id = id_pool[$urandom_range(0, 3)] ^ (32'h1 << $urandom_range(0, 31));
      end
      pick = $urandom_range(0, 99);
      if (pick < 85 || (!pooled && pick >= 95)) begin
        clock_ms = clock_ms + $urandom_range(0, 3);
        stamp    = clock_ms;
      end else if (pick < 95) begin
        stamp = clock_ms - $urandom_range(0, 50);
      end else if (pick < 98) begin
        stamp = $urandom;
      end else begin
        stamp = ($urandom_range(0, 1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      end
      send_heartbeat(id, stamp);
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
